/* sv/cpu65_pkg.sv */
// Shared types, constants and the opcode decode function of the 6502 step core.
// Used by cpu_6502_instruction_step, its checker and its testbench; depends on nothing.
`timescale 1ns / 1ps

package cpu65_pkg;

    localparam int MEM_W     = 8;
    localparam int MEM_DEPTH = 65536;
    localparam int ADDR_W    = 16;

    localparam int F_C = 0;
    localparam int F_Z = 1;
    localparam int F_I = 2;
    localparam int F_D = 3;
    localparam int F_B = 4;
    localparam int F_U = 5;
    localparam int F_V = 6;
    localparam int F_N = 7;

    localparam logic [15:0] VEC_RST = 16'hFFFC;
    localparam logic [15:0] VEC_NMI = 16'hFFFA;
    localparam logic [15:0] VEC_IRQ = 16'hFFFE;
    localparam logic [7:0]  STACK_PAGE = 8'h01;
    localparam logic [7:0]  SP_RESET   = 8'hFD;
    localparam logic [7:0]  P_RESET    = 8'h34;
    localparam logic [2:0]  CYC_INT    = 3'd7;

    typedef enum logic [1:0] {
        OP_RUN = 2'd0,
        OP_WR  = 2'd1,
        OP_RD  = 2'd2,
        OP_RST = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic        nmi_set;
        logic        irq_line;
    } t_req;

    typedef struct packed {
        logic [15:0] pc_out;
        logic [7:0]  acc_out;
        logic [7:0]  x_out;
        logic [7:0]  y_out;
        logic [7:0]  sp_out;
        logic [7:0]  flags_out;
        logic [4:0]  cycles;
        logic [7:0]  rdata;
    } t_rsp;

    typedef enum logic [5:0] {
        I_XX, I_ADC, I_AND, I_ASL, I_BCC, I_BCS, I_BEQ, I_BIT, I_BMI, I_BNE, I_BPL,
        I_BRK, I_BVC, I_BVS, I_CLC, I_CLD, I_CLI, I_CLV, I_CMP, I_CPX, I_CPY, I_DEC,
        I_DEX, I_DEY, I_EOR, I_INC, I_INX, I_INY, I_JMP, I_JSR, I_LDA, I_LDX, I_LDY,
        I_LSR, I_NOP, I_ORA, I_PHA, I_PHP, I_PLA, I_PLP, I_ROL, I_ROR, I_RTI, I_RTS,
        I_SBC, I_SEC, I_SED, I_SEI, I_STA, I_STX, I_STY, I_TAX, I_TAY, I_TSX, I_TXA,
        I_TXS, I_TYA
    } t_ins;

    typedef enum logic [3:0] {
        M_IMP, M_ACC, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY, M_IND,
        M_IZX, M_IZY, M_REL
    } t_mode;

    typedef struct packed {
        t_ins        ins;
        t_mode       mode;
        logic [2:0]  cyc;
    } t_dec;

    function automatic t_dec mk(t_ins ins, t_mode mode, logic [2:0] cyc);
        t_dec d;
        d.ins  = ins;
        d.mode = mode;
        d.cyc  = cyc;
        return d;
    endfunction

    function automatic logic [7:0] zn_flags(logic [7:0] p, logic [7:0] v);
        logic [7:0] q;
        q      = p;
        q[F_Z] = (v == 8'h00);
        q[F_N] = v[7];
        return q;
    endfunction

    function automatic logic page_penalty(t_ins ins);
        logic r;
        case (ins) inside
            I_ORA, I_AND, I_EOR, I_ADC, I_SBC, I_LDA, I_LDX, I_LDY, I_CMP: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_dec decode(logic [7:0] opc);
        t_dec d;
        unique case (opc)
            8'h00: d = mk(I_BRK, M_IMP, 3'd7);
            8'h01: d = mk(I_ORA, M_IZX, 3'd6);
            8'h05: d = mk(I_ORA, M_ZP,  3'd3);
            8'h06: d = mk(I_ASL, M_ZP,  3'd5);
            8'h08: d = mk(I_PHP, M_IMP, 3'd3);
            8'h09: d = mk(I_ORA, M_IMM, 3'd2);
            8'h0A: d = mk(I_ASL, M_ACC, 3'd2);
            8'h0D: d = mk(I_ORA, M_ABS, 3'd4);
            8'h0E: d = mk(I_ASL, M_ABS, 3'd6);
            8'h10: d = mk(I_BPL, M_REL, 3'd2);
            8'h11: d = mk(I_ORA, M_IZY, 3'd5);
            8'h15: d = mk(I_ORA, M_ZPX, 3'd4);
            8'h16: d = mk(I_ASL, M_ZPX, 3'd6);
            8'h18: d = mk(I_CLC, M_IMP, 3'd2);
            8'h19: d = mk(I_ORA, M_ABY, 3'd4);
            8'h1D: d = mk(I_ORA, M_ABX, 3'd4);
            8'h1E: d = mk(I_ASL, M_ABX, 3'd7);
            8'h20: d = mk(I_JSR, M_ABS, 3'd6);
            8'h21: d = mk(I_AND, M_IZX, 3'd6);
            8'h24: d = mk(I_BIT, M_ZP,  3'd3);
            8'h25: d = mk(I_AND, M_ZP,  3'd3);
            8'h26: d = mk(I_ROL, M_ZP,  3'd5);
            8'h28: d = mk(I_PLP, M_IMP, 3'd4);
            8'h29: d = mk(I_AND, M_IMM, 3'd2);
            8'h2A: d = mk(I_ROL, M_ACC, 3'd2);
            8'h2C: d = mk(I_BIT, M_ABS, 3'd4);
            8'h2D: d = mk(I_AND, M_ABS, 3'd4);
            8'h2E: d = mk(I_ROL, M_ABS, 3'd6);
            8'h30: d = mk(I_BMI, M_REL, 3'd2);
            8'h31: d = mk(I_AND, M_IZY, 3'd5);
            8'h35: d = mk(I_AND, M_ZPX, 3'd4);
            8'h36: d = mk(I_ROL, M_ZPX, 3'd6);
            8'h38: d = mk(I_SEC, M_IMP, 3'd2);
            8'h39: d = mk(I_AND, M_ABY, 3'd4);
            8'h3D: d = mk(I_AND, M_ABX, 3'd4);
            8'h3E: d = mk(I_ROL, M_ABX, 3'd7);
            8'h40: d = mk(I_RTI, M_IMP, 3'd6);
            8'h41: d = mk(I_EOR, M_IZX, 3'd6);
            8'h45: d = mk(I_EOR, M_ZP,  3'd3);
            8'h46: d = mk(I_LSR, M_ZP,  3'd5);
            8'h48: d = mk(I_PHA, M_IMP, 3'd3);
            8'h49: d = mk(I_EOR, M_IMM, 3'd2);
            8'h4A: d = mk(I_LSR, M_ACC, 3'd2);
            8'h4C: d = mk(I_JMP, M_ABS, 3'd3);
            8'h4D: d = mk(I_EOR, M_ABS, 3'd4);
            8'h4E: d = mk(I_LSR, M_ABS, 3'd6);
            8'h50: d = mk(I_BVC, M_REL, 3'd2);
            8'h51: d = mk(I_EOR, M_IZY, 3'd5);
            8'h55: d = mk(I_EOR, M_ZPX, 3'd4);
            8'h56: d = mk(I_LSR, M_ZPX, 3'd6);
            8'h58: d = mk(I_CLI, M_IMP, 3'd2);
            8'h59: d = mk(I_EOR, M_ABY, 3'd4);
            8'h5D: d = mk(I_EOR, M_ABX, 3'd4);
            8'h5E: d = mk(I_LSR, M_ABX, 3'd7);
            8'h60: d = mk(I_RTS, M_IMP, 3'd6);
            8'h61: d = mk(I_ADC, M_IZX, 3'd6);
            8'h65: d = mk(I_ADC, M_ZP,  3'd3);
            8'h66: d = mk(I_ROR, M_ZP,  3'd5);
            8'h68: d = mk(I_PLA, M_IMP, 3'd4);
            8'h69: d = mk(I_ADC, M_IMM, 3'd2);
            8'h6A: d = mk(I_ROR, M_ACC, 3'd2);
            8'h6C: d = mk(I_JMP, M_IND, 3'd5);
            8'h6D: d = mk(I_ADC, M_ABS, 3'd4);
            8'h6E: d = mk(I_ROR, M_ABS, 3'd6);
            8'h70: d = mk(I_BVS, M_REL, 3'd2);
            8'h71: d = mk(I_ADC, M_IZY, 3'd5);
            8'h75: d = mk(I_ADC, M_ZPX, 3'd4);
            8'h76: d = mk(I_ROR, M_ZPX, 3'd6);
            8'h78: d = mk(I_SEI, M_IMP, 3'd2);
            8'h79: d = mk(I_ADC, M_ABY, 3'd4);
            8'h7D: d = mk(I_ADC, M_ABX, 3'd4);
            8'h7E: d = mk(I_ROR, M_ABX, 3'd7);
            8'h81: d = mk(I_STA, M_IZX, 3'd6);
            8'h84: d = mk(I_STY, M_ZP,  3'd3);
            8'h85: d = mk(I_STA, M_ZP,  3'd3);
            8'h86: d = mk(I_STX, M_ZP,  3'd3);
            8'h88: d = mk(I_DEY, M_IMP, 3'd2);
            8'h8A: d = mk(I_TXA, M_IMP, 3'd2);
            8'h8C: d = mk(I_STY, M_ABS, 3'd4);
            8'h8D: d = mk(I_STA, M_ABS, 3'd4);
            8'h8E: d = mk(I_STX, M_ABS, 3'd4);
            8'h90: d = mk(I_BCC, M_REL, 3'd2);
            8'h91: d = mk(I_STA, M_IZY, 3'd6);
            8'h94: d = mk(I_STY, M_ZPX, 3'd4);
            8'h95: d = mk(I_STA, M_ZPX, 3'd4);
            8'h96: d = mk(I_STX, M_ZPY, 3'd4);
            8'h98: d = mk(I_TYA, M_IMP, 3'd2);
            8'h99: d = mk(I_STA, M_ABY, 3'd5);
            8'h9A: d = mk(I_TXS, M_IMP, 3'd2);
            8'h9D: d = mk(I_STA, M_ABX, 3'd5);
            8'hA0: d = mk(I_LDY, M_IMM, 3'd2);
            8'hA1: d = mk(I_LDA, M_IZX, 3'd6);
            8'hA2: d = mk(I_LDX, M_IMM, 3'd2);
            8'hA4: d = mk(I_LDY, M_ZP,  3'd3);
            8'hA5: d = mk(I_LDA, M_ZP,  3'd3);
            8'hA6: d = mk(I_LDX, M_ZP,  3'd3);
            8'hA8: d = mk(I_TAY, M_IMP, 3'd2);
            8'hA9: d = mk(I_LDA, M_IMM, 3'd2);
            8'hAA: d = mk(I_TAX, M_IMP, 3'd2);
            8'hAC: d = mk(I_LDY, M_ABS, 3'd4);
            8'hAD: d = mk(I_LDA, M_ABS, 3'd4);
            8'hAE: d = mk(I_LDX, M_ABS, 3'd4);
            8'hB0: d = mk(I_BCS, M_REL, 3'd2);
            8'hB1: d = mk(I_LDA, M_IZY, 3'd5);
            8'hB4: d = mk(I_LDY, M_ZPX, 3'd4);
            8'hB5: d = mk(I_LDA, M_ZPX, 3'd4);
            8'hB6: d = mk(I_LDX, M_ZPY, 3'd4);
            8'hB8: d = mk(I_CLV, M_IMP, 3'd2);
            8'hB9: d = mk(I_LDA, M_ABY, 3'd4);
            8'hBA: d = mk(I_TSX, M_IMP, 3'd2);
            8'hBC: d = mk(I_LDY, M_ABX, 3'd4);
            8'hBD: d = mk(I_LDA, M_ABX, 3'd4);
            8'hBE: d = mk(I_LDX, M_ABY, 3'd4);
            8'hC0: d = mk(I_CPY, M_IMM, 3'd2);
            8'hC1: d = mk(I_CMP, M_IZX, 3'd6);
            8'hC4: d = mk(I_CPY, M_ZP,  3'd3);
            8'hC5: d = mk(I_CMP, M_ZP,  3'd3);
            8'hC6: d = mk(I_DEC, M_ZP,  3'd5);
            8'hC8: d = mk(I_INY, M_IMP, 3'd2);
            8'hC9: d = mk(I_CMP, M_IMM, 3'd2);
            8'hCA: d = mk(I_DEX, M_IMP, 3'd2);
            8'hCC: d = mk(I_CPY, M_ABS, 3'd4);
            8'hCD: d = mk(I_CMP, M_ABS, 3'd4);
            8'hCE: d = mk(I_DEC, M_ABS, 3'd6);
            8'hD0: d = mk(I_BNE, M_REL, 3'd2);
            8'hD1: d = mk(I_CMP, M_IZY, 3'd5);
            8'hD5: d = mk(I_CMP, M_ZPX, 3'd4);
            8'hD6: d = mk(I_DEC, M_ZPX, 3'd6);
            8'hD8: d = mk(I_CLD, M_IMP, 3'd2);
            8'hD9: d = mk(I_CMP, M_ABY, 3'd4);
            8'hDD: d = mk(I_CMP, M_ABX, 3'd4);
            8'hDE: d = mk(I_DEC, M_ABX, 3'd7);
            8'hE0: d = mk(I_CPX, M_IMM, 3'd2);
            8'hE1: d = mk(I_SBC, M_IZX, 3'd6);
            8'hE4: d = mk(I_CPX, M_ZP,  3'd3);
            8'hE5: d = mk(I_SBC, M_ZP,  3'd3);
            8'hE6: d = mk(I_INC, M_ZP,  3'd5);
            8'hE8: d = mk(I_INX, M_IMP, 3'd2);
            8'hE9: d = mk(I_SBC, M_IMM, 3'd2);
            8'hEA: d = mk(I_NOP, M_IMP, 3'd2);
            8'hEC: d = mk(I_CPX, M_ABS, 3'd4);
            8'hED: d = mk(I_SBC, M_ABS, 3'd4);
            8'hEE: d = mk(I_INC, M_ABS, 3'd6);
            8'hF0: d = mk(I_BEQ, M_REL, 3'd2);
            8'hF1: d = mk(I_SBC, M_IZY, 3'd5);
            8'hF5: d = mk(I_SBC, M_ZPX, 3'd4);
            8'hF6: d = mk(I_INC, M_ZPX, 3'd6);
            8'hF8: d = mk(I_SED, M_IMP, 3'd2);
            8'hF9: d = mk(I_SBC, M_ABY, 3'd4);
            8'hFD: d = mk(I_SBC, M_ABX, 3'd4);
            8'hFE: d = mk(I_INC, M_ABX, 3'd7);
            default: d = mk(I_XX, M_IMP, 3'd2);
        endcase
        return d;
    endfunction

endpackage

/* sv/cpu65_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing; used by cpu_6502_instruction_step.
`timescale 1ns / 1ps

module cpu65_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/cpu_6502_instruction_step.sv */
// Instruction-level 6502 core with a private 64 KiB memory, one request per result.
// Depends on cpu65_pkg and cpu65_ram.
`timescale 1ns / 1ps

// Every request returns one result with the registers after it. The memory is a
// single-port RAM and the sequencer makes one access per cycle, so a run request
// spends its time on fetch, operand and pointer reads, stack pushes and pulls, and
// on the stack pushes and vector reads when an interrupt is entered first. One
// request may wait in an input register while another is in work, and a finished
// result waits in the output register. After power-on the program counter is zero
// until a reset request loads it from the vector at 0xFFFC.
module cpu_6502_instruction_step
    import cpu65_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);

    typedef enum logic [20:0] {
        S_IDLE  = 21'd1,
        S_RDQ   = 21'd2,
        S_PSH1  = 21'd4,
        S_PSH2  = 21'd8,
        S_PSH3  = 21'd16,
        S_VEC0  = 21'd32,
        S_VEC1  = 21'd64,
        S_VEC2  = 21'd128,
        S_FETCH = 21'd256,
        S_DEC   = 21'd512,
        S_A1    = 21'd1024,
        S_A2    = 21'd2048,
        S_P1    = 21'd4096,
        S_P2    = 21'd8192,
        S_LOAD  = 21'd16384,
        S_EXEC  = 21'd32768,
        S_JSR2  = 21'd65536,
        S_PL1   = 21'd131072,
        S_PL2   = 21'd262144,
        S_PL3   = 21'd524288,
        S_DONE  = 21'd1048576
    } t_state;

    t_state r_state, n_state;
    logic   r_buf_vld, r_out_vld, r_nmi, n_nmi;
    t_req   r_buf;
    t_rsp   r_out;
    logic [15:0] r_pc, n_pc, r_ea, n_ea, r_base, n_base, r_vec, n_vec;
    logic [7:0]  r_a, n_a, r_x, n_x, r_y, n_y, r_sp, n_sp, r_p, n_p;
    logic [7:0]  r_t, n_t, r_rdata, n_rdata;
    logic [4:0]  r_cyc, n_cyc;
    logic        r_brk, n_brk, r_vec_run, n_vec_run;
    t_dec        r_dec, n_dec, dec;

    logic        mem_we;
    logic [15:0] mem_addr;
    logic [7:0]  mem_wdata, mem_q;

    logic        start, out_free;
    logic [7:0]  alu_m, cmp_reg, sh_src, sh_res, logic_v;
    logic [8:0]  adc_s, cmp_d;
    logic        adc_v, sh_c, br_take;
    logic [15:0] br_tgt, idx_sum, ret_pc;

    cpu65_ram #(.WIDTH(MEM_W), .DEPTH(MEM_DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_q)
    );

    assign start       = (r_state == S_IDLE) && r_buf_vld;
    assign out_free    = !r_out_vld || !i_rsp_stall;
    assign o_req_stall = r_buf_vld;
    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_out;
    assign dec         = decode(mem_q);

    always_comb begin
        alu_m   = (r_dec.ins == I_SBC) ? ~mem_q : mem_q;
        adc_s   = {1'b0, r_a} + {1'b0, alu_m} + {8'h00, r_p[F_C]};
        adc_v   = ~(r_a[7] ^ alu_m[7]) & (r_a[7] ^ adc_s[7]);
        cmp_reg = (r_dec.ins == I_CPX) ? r_x : ((r_dec.ins == I_CPY) ? r_y : r_a);
        cmp_d   = {1'b0, cmp_reg} - {1'b0, mem_q};
        sh_src  = (r_dec.mode == M_ACC) ? r_a : mem_q;
        case (r_dec.ins)
            I_ASL:   {sh_c, sh_res} = {sh_src, 1'b0};
            I_ROL:   {sh_c, sh_res} = {sh_src, r_p[F_C]};
            I_LSR:   {sh_res, sh_c} = {1'b0, sh_src};
            default: {sh_res, sh_c} = {r_p[F_C], sh_src};
        endcase
        case (r_dec.ins)
            I_AND:   logic_v = r_a & mem_q;
            I_ORA:   logic_v = r_a | mem_q;
            default: logic_v = r_a ^ mem_q;
        endcase
        case (r_dec.ins)
            I_BCC:   br_take = !r_p[F_C];
            I_BCS:   br_take = r_p[F_C];
            I_BEQ:   br_take = r_p[F_Z];
            I_BNE:   br_take = !r_p[F_Z];
            I_BMI:   br_take = r_p[F_N];
            I_BPL:   br_take = !r_p[F_N];
            I_BVS:   br_take = r_p[F_V];
            default: br_take = !r_p[F_V];
        endcase
        br_tgt  = r_pc + {{8{r_ea[7]}}, r_ea[7:0]};
        idx_sum = {mem_q, r_t} + {8'h00, (r_dec.mode == M_ABY) ? r_y : r_x};
        ret_pc  = r_pc - 16'd1;
    end

    always_comb begin
        n_state   = r_state;
        n_nmi     = r_nmi;
        n_pc      = r_pc;
        n_a       = r_a;
        n_x       = r_x;
        n_y       = r_y;
        n_sp      = r_sp;
        n_p       = r_p;
        n_ea      = r_ea;
        n_base    = r_base;
        n_vec     = r_vec;
        n_t       = r_t;
        n_rdata   = r_rdata;
        n_cyc     = r_cyc;
        n_brk     = r_brk;
        n_vec_run = r_vec_run;
        n_dec     = r_dec;
        mem_we    = 1'b0;
        mem_addr  = r_pc;
        mem_wdata = 8'h00;

        unique case (r_state)
            S_IDLE: begin
                if (r_buf_vld) begin
                    n_nmi   = r_nmi | r_buf.nmi_set;
                    n_cyc   = 5'd0;
                    n_rdata = 8'h00;
                    mem_addr = r_buf.addr;
                    unique case (t_op'(r_buf.op))
                        OP_WR: begin
                            mem_we    = 1'b1;
                            mem_wdata = r_buf.wdata;
                            n_state   = S_DONE;
                        end
                        OP_RD: begin
                            n_state = S_RDQ;
                        end
                        OP_RST: begin
                            n_a       = 8'h00;
                            n_x       = 8'h00;
                            n_y       = 8'h00;
                            n_sp      = SP_RESET;
                            n_p       = P_RESET;
                            n_vec     = VEC_RST;
                            n_vec_run = 1'b0;
                            n_state   = S_VEC0;
                        end
                        default: begin
                            n_brk     = 1'b0;
                            n_vec_run = 1'b1;
                            if (n_nmi) begin
                                n_nmi   = 1'b0;
                                n_vec   = VEC_NMI;
                                n_cyc   = 5'(CYC_INT);
                                n_state = S_PSH1;
                            end else if (r_buf.irq_line && !r_p[F_I]) begin
                                n_vec   = VEC_IRQ;
                                n_cyc   = 5'(CYC_INT);
                                n_state = S_PSH1;
                            end else begin
                                n_state = S_FETCH;
                            end
                        end
                    endcase
                end
            end
            S_RDQ: begin
                n_rdata = mem_q;
                n_state = S_DONE;
            end
            S_PSH1: begin
                mem_we    = 1'b1;
                mem_addr  = {STACK_PAGE, r_sp};
                mem_wdata = r_pc[15:8];
                n_sp      = r_sp - 8'd1;
                n_state   = S_PSH2;
            end
            S_PSH2: begin
                mem_we    = 1'b1;
                mem_addr  = {STACK_PAGE, r_sp};
                mem_wdata = r_pc[7:0];
                n_sp      = r_sp - 8'd1;
                n_state   = S_PSH3;
            end
            S_PSH3: begin
                n_p       = r_p;
                n_p[F_B]  = r_brk;
                n_p[F_U]  = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = {STACK_PAGE, r_sp};
                mem_wdata = n_p;
                n_p[F_I]  = 1'b1;
                n_sp      = r_sp - 8'd1;
                n_state   = S_VEC0;
            end
            S_VEC0: begin
                mem_addr = r_vec;
                n_state  = S_VEC1;
            end
            S_VEC1: begin
                n_t      = mem_q;
                mem_addr = r_vec + 16'd1;
                n_state  = S_VEC2;
            end
            S_VEC2: begin
                n_pc    = {mem_q, r_t};
                n_state = r_vec_run ? S_FETCH : S_DONE;
            end
            S_FETCH: begin
                mem_addr = r_pc;
                n_state  = S_DEC;
            end
            S_DEC: begin
                n_dec    = dec;
                n_cyc    = r_cyc + 5'(dec.cyc);
                mem_addr = r_pc + 16'd1;
                unique case (dec.mode)
                    M_IMP, M_ACC: begin
                        n_pc    = r_pc + 16'd1;
                        n_state = S_EXEC;
                    end
                    M_IMM: begin
                        n_ea    = r_pc + 16'd1;
                        n_pc    = r_pc + 16'd2;
                        n_state = S_LOAD;
                    end
                    default: begin
                        n_pc    = r_pc + 16'd1;
                        n_state = S_A1;
                    end
                endcase
            end
            S_A1: begin
                n_pc     = r_pc + 16'd1;
                mem_addr = r_pc + 16'd1;
                n_state  = S_LOAD;
                unique case (r_dec.mode)
                    M_ZPX: n_ea = {8'h00, mem_q + r_x};
                    M_ZPY: n_ea = {8'h00, mem_q + r_y};
                    M_IZX: begin
                        n_base   = {8'h00, mem_q + r_x};
                        mem_addr = {8'h00, mem_q + r_x};
                        n_state  = S_P1;
                    end
                    M_IZY: begin
                        n_base   = {8'h00, mem_q};
                        mem_addr = {8'h00, mem_q};
                        n_state  = S_P1;
                    end
                    M_ABS, M_ABX, M_ABY, M_IND: begin
                        n_t     = mem_q;
                        n_state = S_A2;
                    end
                    default: n_ea = {8'h00, mem_q};
                endcase
            end
            S_A2: begin
                n_pc    = r_pc + 16'd1;
                n_state = S_LOAD;
                unique case (r_dec.mode)
                    M_ABX, M_ABY: begin
                        n_ea = idx_sum;
                        if ((idx_sum[15:8] != mem_q) && page_penalty(r_dec.ins)) begin
                            n_cyc = r_cyc + 5'd1;
                        end
                    end
                    M_IND: begin
                        n_base   = {mem_q, r_t};
                        mem_addr = {mem_q, r_t};
                        n_state  = S_P1;
                    end
                    default: n_ea = {mem_q, r_t};
                endcase
            end
            S_P1: begin
                n_t      = mem_q;
                mem_addr = {r_base[15:8], r_base[7:0] + 8'd1};
                n_state  = S_P2;
            end
            S_P2: begin
                n_ea    = {mem_q, r_t};
                n_state = S_LOAD;
                if (r_dec.mode == M_IZY) begin
                    n_ea = {mem_q, r_t} + {8'h00, r_y};
                    if ((n_ea[15:8] != mem_q) && page_penalty(r_dec.ins)) begin
                        n_cyc = r_cyc + 5'd1;
                    end
                end
            end
            S_LOAD: begin
                mem_addr = r_ea;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                n_state  = S_DONE;
                mem_addr = r_ea;
                unique case (r_dec.ins) inside
                    I_ADC, I_SBC: begin
                        n_a      = adc_s[7:0];
                        n_p      = zn_flags(r_p, adc_s[7:0]);
                        n_p[F_C] = adc_s[8];
                        n_p[F_V] = adc_v;
                    end
                    I_AND, I_ORA, I_EOR: begin
                        n_a = logic_v;
                        n_p = zn_flags(r_p, logic_v);
                    end
                    I_ASL, I_LSR, I_ROL, I_ROR: begin
                        n_p      = zn_flags(r_p, sh_res);
                        n_p[F_C] = sh_c;
                        if (r_dec.mode == M_ACC) begin
                            n_a = sh_res;
                        end else begin
                            mem_we    = 1'b1;
                            mem_wdata = sh_res;
                        end
                    end
                    I_BCC, I_BCS, I_BEQ, I_BNE, I_BMI, I_BPL, I_BVS, I_BVC: begin
                        if (br_take) begin
                            n_pc  = br_tgt;
                            n_cyc = r_cyc + ((br_tgt[15:8] != r_pc[15:8]) ? 5'd2 : 5'd1);
                        end
                    end
                    I_BIT: begin
                        n_p[F_Z] = ((r_a & mem_q) == 8'h00);
                        n_p[F_V] = mem_q[6];
                        n_p[F_N] = mem_q[7];
                    end
                    I_BRK: begin
                        n_pc      = r_pc + 16'd1;
                        n_brk     = 1'b1;
                        n_vec     = VEC_IRQ;
                        n_vec_run = 1'b0;
                        n_state   = S_PSH1;
                    end
                    I_CLC: n_p[F_C] = 1'b0;
                    I_CLD: n_p[F_D] = 1'b0;
                    I_CLI: n_p[F_I] = 1'b0;
                    I_CLV: n_p[F_V] = 1'b0;
                    I_SEC: n_p[F_C] = 1'b1;
                    I_SED: n_p[F_D] = 1'b1;
                    I_SEI: n_p[F_I] = 1'b1;
                    I_CMP, I_CPX, I_CPY: begin
                        n_p      = zn_flags(r_p, cmp_d[7:0]);
                        n_p[F_C] = !cmp_d[8];
                    end
                    I_DEC: begin
                        mem_we    = 1'b1;
                        mem_wdata = mem_q - 8'd1;
                        n_p       = zn_flags(r_p, mem_wdata);
                    end
                    I_INC: begin
                        mem_we    = 1'b1;
                        mem_wdata = mem_q + 8'd1;
                        n_p       = zn_flags(r_p, mem_wdata);
                    end
                    I_DEX: begin
                        n_x = r_x - 8'd1;
                        n_p = zn_flags(r_p, n_x);
                    end
                    I_DEY: begin
                        n_y = r_y - 8'd1;
                        n_p = zn_flags(r_p, n_y);
                    end
                    I_INX: begin
                        n_x = r_x + 8'd1;
                        n_p = zn_flags(r_p, n_x);
                    end
                    I_INY: begin
                        n_y = r_y + 8'd1;
                        n_p = zn_flags(r_p, n_y);
                    end
                    I_JMP: n_pc = r_ea;
                    I_JSR: begin
                        mem_we    = 1'b1;
                        mem_addr  = {STACK_PAGE, r_sp};
                        mem_wdata = ret_pc[15:8];
                        n_t       = ret_pc[7:0];
                        n_sp      = r_sp - 8'd1;
                        n_state   = S_JSR2;
                    end
                    I_LDA: begin
                        n_a = mem_q;
                        n_p = zn_flags(r_p, mem_q);
                    end
                    I_LDX: begin
                        n_x = mem_q;
                        n_p = zn_flags(r_p, mem_q);
                    end
                    I_LDY: begin
                        n_y = mem_q;
                        n_p = zn_flags(r_p, mem_q);
                    end
                    I_PHA, I_PHP: begin
                        mem_we    = 1'b1;
                        mem_addr  = {STACK_PAGE, r_sp};
                        n_sp      = r_sp - 8'd1;
                        if (r_dec.ins == I_PHA) begin
                            mem_wdata = r_a;
                        end else begin
                            n_p[F_U]  = 1'b1;
                            mem_wdata = r_p | 8'h30;
                        end
                    end
                    I_PLA, I_PLP, I_RTI, I_RTS: begin
                        mem_addr = {STACK_PAGE, r_sp + 8'd1};
                        n_sp     = r_sp + 8'd1;
                        n_state  = S_PL1;
                    end
                    I_STA, I_STX, I_STY: begin
                        mem_we = 1'b1;
                        case (r_dec.ins)
                            I_STA:   mem_wdata = r_a;
                            I_STX:   mem_wdata = r_x;
                            default: mem_wdata = r_y;
                        endcase
                    end
                    I_TAX: begin
                        n_x = r_a;
                        n_p = zn_flags(r_p, r_a);
                    end
                    I_TAY: begin
                        n_y = r_a;
                        n_p = zn_flags(r_p, r_a);
                    end
                    I_TSX: begin
                        n_x = r_sp;
                        n_p = zn_flags(r_p, r_sp);
                    end
                    I_TXA: begin
                        n_a = r_x;
                        n_p = zn_flags(r_p, r_x);
                    end
                    I_TXS: n_sp = r_x;
                    I_TYA: begin
                        n_a = r_y;
                        n_p = zn_flags(r_p, r_y);
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_JSR2: begin
                mem_we    = 1'b1;
                mem_addr  = {STACK_PAGE, r_sp};
                mem_wdata = r_t;
                n_sp      = r_sp - 8'd1;
                n_pc      = r_ea;
                n_state   = S_DONE;
            end
            S_PL1: begin
                mem_addr = {STACK_PAGE, r_sp + 8'd1};
                n_state  = S_DONE;
                unique case (r_dec.ins) inside
                    I_PLA: begin
                        n_a = mem_q;
                        n_p = zn_flags(r_p, mem_q);
                    end
                    I_RTI: begin
                        n_p      = mem_q;
                        n_p[F_B] = 1'b0;
                        n_p[F_U] = 1'b1;
                        n_sp     = r_sp + 8'd1;
                        n_state  = S_PL2;
                    end
                    I_RTS: begin
                        n_t     = mem_q;
                        n_sp    = r_sp + 8'd1;
                        n_state = S_PL3;
                    end
                    default: begin
                        n_p      = mem_q;
                        n_p[F_B] = 1'b0;
                        n_p[F_U] = 1'b1;
                    end
                endcase
            end
            S_PL2: begin
                n_t      = mem_q;
                mem_addr = {STACK_PAGE, r_sp + 8'd1};
                n_sp     = r_sp + 8'd1;
                n_state  = S_PL3;
            end
            S_PL3: begin
                n_pc    = {mem_q, r_t} + ((r_dec.ins == I_RTS) ? 16'd1 : 16'd0);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_buf_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_nmi     <= 1'b0;
            r_pc      <= 16'h0000;
            r_a       <= 8'h00;
            r_x       <= 8'h00;
            r_y       <= 8'h00;
            r_sp      <= SP_RESET;
            r_p       <= P_RESET;
        end else begin
            r_state <= n_state;
            r_nmi   <= n_nmi;
            r_pc    <= n_pc;
            r_a     <= n_a;
            r_x     <= n_x;
            r_y     <= n_y;
            r_sp    <= n_sp;
            r_p     <= n_p;
            if (!r_buf_vld && i_req_valid) begin
                r_buf_vld <= 1'b1;
            end else if (start) begin
                r_buf_vld <= 1'b0;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ea      <= n_ea;
        r_base    <= n_base;
        r_vec     <= n_vec;
        r_t       <= n_t;
        r_rdata   <= n_rdata;
        r_cyc     <= n_cyc;
        r_brk     <= n_brk;
        r_vec_run <= n_vec_run;
        r_dec     <= n_dec;
        if (!r_buf_vld && i_req_valid) begin
            r_buf <= i_req;
        end
        if (r_state == S_DONE && out_free) begin
            r_out.pc_out    <= r_pc;
            r_out.acc_out   <= r_a;
            r_out.x_out     <= r_x;
            r_out.y_out     <= r_y;
            r_out.sp_out    <= r_sp;
            r_out.flags_out <= r_p;
            r_out.cycles    <= r_cyc;
            r_out.rdata     <= r_rdata;
        end
    end

`ifndef SYNTHESIS
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_buf_vld) |-> !mem_we)
        else $error("memory written while the sequencer is idle");

    a_start_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> !r_buf_vld)
        else $error("input register not released after a request started");

    a_cycle_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.cycles <= 5'd14))
        else $error("cycle count above interrupt plus longest instruction");
`endif

endmodule

/* dv/cpu_6502_instruction_step_chk.sv */
// Checker for the 6502 step core: watches both channels, predicts every result
// and compares it as a whole. Depends on cpu65_pkg for the payload types.
`timescale 1ns / 1ps

module cpu_6502_instruction_step_chk
    import cpu65_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_stall,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_stall,
    input  t_rsp i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    logic [7:0]  mem [0:65535];
    logic [15:0] pc;
    logic [7:0]  a, x, y, sp, p;
    logic        nmi_latched;
    t_rsp        results_due [$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = results_due.size();

    function automatic logic [7:0] rd(logic [15:0] addr);
        return mem[addr];
    endfunction

    function automatic logic [15:0] rd16(logic [15:0] addr);
        return {rd(addr + 16'd1), rd(addr)};
    endfunction

    function automatic logic [15:0] rd16_page(logic [15:0] addr);
        logic [15:0] hi;
        hi = {addr[15:8], addr[7:0] + 8'd1};
        return {rd(hi), rd(addr)};
    endfunction

    task automatic push(logic [7:0] v);
        mem[{8'h01, sp}] = v;
        sp = sp - 8'd1;
    endtask

    task automatic pull(output logic [7:0] v);
        sp = sp + 8'd1;
        v = mem[{8'h01, sp}];
    endtask

    task automatic set_zn(logic [7:0] v);
        p[F_Z] = (v == 8'h00);
        p[F_N] = v[7];
    endtask

    task automatic enter_vector(logic [15:0] vec, logic brk);
        push(pc[15:8]);
        push(pc[7:0]);
        p[F_B] = brk;
        p[F_U] = 1'b1;
        push(p);
        p[F_I] = 1'b1;
        pc = rd16(vec);
    endtask

    task automatic add_carry(logic [7:0] m);
        logic [8:0] s;
        logic [7:0] r;
        s = {1'b0, a} + {1'b0, m} + {8'h00, p[F_C]};
        r = s[7:0];
        p[F_C] = s[8];
        p[F_V] = (~(a ^ m) & (a ^ r)) >> 7;
        a = r;
        set_zn(r);
    endtask

    task automatic compare(logic [7:0] r, logic [7:0] m);
        set_zn(r - m);
        p[F_C] = (r >= m);
    endtask

    task automatic branch(logic cond, logic [7:0] off, inout int cyc);
        logic [15:0] tgt;
        if (cond) begin
            tgt = pc + {{8{off[7]}}, off};
            cyc += (tgt[15:8] != pc[15:8]) ? 2 : 1;
            pc = tgt;
        end
    endtask

    // Opcode table built from the regular column layout of the NMOS set.
    task automatic opcode_info(logic [7:0] opc, output t_ins ins, output t_mode mode,
                               output int cyc);
        logic [2:0] hi3, mid3;
        hi3  = opc[7:5];
        mid3 = opc[4:2];
        ins  = I_XX;
        mode = M_IMP;
        cyc  = 2;
        if (opc[1:0] == 2'b01 && opc != 8'h89) begin
            case (hi3)
                3'd0: ins = I_ORA;
                3'd1: ins = I_AND;
                3'd2: ins = I_EOR;
                3'd3: ins = I_ADC;
                3'd4: ins = I_STA;
                3'd5: ins = I_LDA;
                3'd6: ins = I_CMP;
                default: ins = I_SBC;
            endcase
            case (mid3)
                3'd0: begin mode = M_IZX; cyc = 6; end
                3'd1: begin mode = M_ZP;  cyc = 3; end
                3'd2: begin mode = M_IMM; cyc = 2; end
                3'd3: begin mode = M_ABS; cyc = 4; end
                3'd4: begin mode = M_IZY; cyc = (ins == I_STA) ? 6 : 5; end
                3'd5: begin mode = M_ZPX; cyc = 4; end
                3'd6: begin mode = M_ABY; cyc = (ins == I_STA) ? 5 : 4; end
                default: begin mode = M_ABX; cyc = (ins == I_STA) ? 5 : 4; end
            endcase
        end else if (opc[1:0] == 2'b10) begin
            case (opc)
                8'h8A: ins = I_TXA;
                8'hAA: ins = I_TAX;
                8'hCA: ins = I_DEX;
                8'hEA: ins = I_NOP;
                8'h9A: ins = I_TXS;
                8'hBA: ins = I_TSX;
                8'hA2: begin ins = I_LDX; mode = M_IMM; end
                default: begin
                    case (hi3)
                        3'd0: ins = I_ASL;
                        3'd1: ins = I_ROL;
                        3'd2: ins = I_LSR;
                        3'd3: ins = I_ROR;
                        3'd4: ins = I_STX;
                        3'd5: ins = I_LDX;
                        3'd6: ins = I_DEC;
                        default: ins = I_INC;
                    endcase
                    case (mid3)
                        3'd1: begin mode = M_ZP; cyc = hi3[2:1] == 2'b10 ? 3 : 5; end
                        3'd2: begin
                            if (hi3 < 3'd4) mode = M_ACC;
                            else ins = I_XX;
                        end
                        3'd3: begin mode = M_ABS; cyc = hi3[2:1] == 2'b10 ? 4 : 6; end
                        3'd5: begin
                            mode = (hi3[2:1] == 2'b10) ? M_ZPY : M_ZPX;
                            cyc = hi3[2:1] == 2'b10 ? 4 : 6;
                        end
                        3'd7: begin
                            if (hi3 == 3'd4) ins = I_XX;
                            else if (hi3 == 3'd5) begin mode = M_ABY; cyc = 4; end
                            else begin mode = M_ABX; cyc = 7; end
                        end
                        default: ins = I_XX;
                    endcase
                end
            endcase
        end else if (opc[1:0] == 2'b00) begin
            case (opc)
                8'h00: begin ins = I_BRK; cyc = 7; end
                8'h08: begin ins = I_PHP; cyc = 3; end
                8'h28: begin ins = I_PLP; cyc = 4; end
                8'h48: begin ins = I_PHA; cyc = 3; end
                8'h68: begin ins = I_PLA; cyc = 4; end
                8'h40: begin ins = I_RTI; cyc = 6; end
                8'h60: begin ins = I_RTS; cyc = 6; end
                8'h20: begin ins = I_JSR; mode = M_ABS; cyc = 6; end
                8'h4C: begin ins = I_JMP; mode = M_ABS; cyc = 3; end
                8'h6C: begin ins = I_JMP; mode = M_IND; cyc = 5; end
                8'h24: begin ins = I_BIT; mode = M_ZP;  cyc = 3; end
                8'h2C: begin ins = I_BIT; mode = M_ABS; cyc = 4; end
                8'h10: begin ins = I_BPL; mode = M_REL; end
                8'h30: begin ins = I_BMI; mode = M_REL; end
                8'h50: begin ins = I_BVC; mode = M_REL; end
                8'h70: begin ins = I_BVS; mode = M_REL; end
                8'h90: begin ins = I_BCC; mode = M_REL; end
                8'hB0: begin ins = I_BCS; mode = M_REL; end
                8'hD0: begin ins = I_BNE; mode = M_REL; end
                8'hF0: begin ins = I_BEQ; mode = M_REL; end
                8'h18: ins = I_CLC;
                8'h38: ins = I_SEC;
                8'h58: ins = I_CLI;
                8'h78: ins = I_SEI;
                8'hB8: ins = I_CLV;
                8'hD8: ins = I_CLD;
                8'hF8: ins = I_SED;
                8'h88: ins = I_DEY;
                8'hC8: ins = I_INY;
                8'hE8: ins = I_INX;
                8'h98: ins = I_TYA;
                8'hA8: ins = I_TAY;
                8'h84: begin ins = I_STY; mode = M_ZP;  cyc = 3; end
                8'h8C: begin ins = I_STY; mode = M_ABS; cyc = 4; end
                8'h94: begin ins = I_STY; mode = M_ZPX; cyc = 4; end
                8'hA0: begin ins = I_LDY; mode = M_IMM; end
                8'hA4: begin ins = I_LDY; mode = M_ZP;  cyc = 3; end
                8'hAC: begin ins = I_LDY; mode = M_ABS; cyc = 4; end
                8'hB4: begin ins = I_LDY; mode = M_ZPX; cyc = 4; end
                8'hBC: begin ins = I_LDY; mode = M_ABX; cyc = 4; end
                8'hC0: begin ins = I_CPY; mode = M_IMM; end
                8'hC4: begin ins = I_CPY; mode = M_ZP;  cyc = 3; end
                8'hCC: begin ins = I_CPY; mode = M_ABS; cyc = 4; end
                8'hE0: begin ins = I_CPX; mode = M_IMM; end
                8'hE4: begin ins = I_CPX; mode = M_ZP;  cyc = 3; end
                8'hEC: begin ins = I_CPX; mode = M_ABS; cyc = 4; end
                default: ins = I_XX;
            endcase
        end
    endtask

    task automatic run_instruction(inout int cyc);
        t_ins        ins;
        t_mode       mode;
        int          base_cyc;
        logic [15:0] pc0, ea, base;
        logic        crossed;
        logic [7:0]  m, r, lo;
        logic [15:0] ret;
        pc0 = pc;
        opcode_info(rd(pc0), ins, mode, base_cyc);
        ea = 16'h0000;
        crossed = 1'b0;
        case (mode)
            M_IMM: begin ea = pc0 + 16'd1; pc = pc0 + 16'd2; end
            M_ZP, M_REL: begin ea = {8'h00, rd(pc0 + 16'd1)}; pc = pc0 + 16'd2; end
            M_ZPX: begin ea = {8'h00, rd(pc0 + 16'd1) + x}; pc = pc0 + 16'd2; end
            M_ZPY: begin ea = {8'h00, rd(pc0 + 16'd1) + y}; pc = pc0 + 16'd2; end
            M_ABS: begin ea = rd16(pc0 + 16'd1); pc = pc0 + 16'd3; end
            M_IND: begin ea = rd16_page(rd16(pc0 + 16'd1)); pc = pc0 + 16'd3; end
            M_ABX, M_ABY: begin
                base = rd16(pc0 + 16'd1);
                ea = base + {8'h00, (mode == M_ABX) ? x : y};
                crossed = (ea[15:8] != base[15:8]);
                pc = pc0 + 16'd3;
            end
            M_IZX: begin
                ea = rd16_page({8'h00, rd(pc0 + 16'd1) + x});
                pc = pc0 + 16'd2;
            end
            M_IZY: begin
                base = rd16_page({8'h00, rd(pc0 + 16'd1)});
                ea = base + {8'h00, y};
                crossed = (ea[15:8] != base[15:8]);
                pc = pc0 + 16'd2;
            end
            default: pc = pc0 + 16'd1;
        endcase
        case (ins)
            I_ORA, I_AND, I_EOR, I_ADC, I_SBC, I_LDA, I_LDX, I_LDY, I_CMP:
                if (crossed) base_cyc++;
            default: ;
        endcase
        case (ins)
            I_ADC: add_carry(rd(ea));
            I_SBC: add_carry(~rd(ea));
            I_AND: begin a = a & rd(ea); set_zn(a); end
            I_ORA: begin a = a | rd(ea); set_zn(a); end
            I_EOR: begin a = a ^ rd(ea); set_zn(a); end
            I_ASL, I_ROL, I_LSR, I_ROR: begin
                m = (mode == M_ACC) ? a : rd(ea);
                if (ins == I_ASL || ins == I_ROL) begin
                    r = {m[6:0], (ins == I_ROL) ? p[F_C] : 1'b0};
                    p[F_C] = m[7];
                end else begin
                    r = {(ins == I_ROR) ? p[F_C] : 1'b0, m[7:1]};
                    p[F_C] = m[0];
                end
                set_zn(r);
                if (mode == M_ACC) a = r;
                else mem[ea] = r;
            end
            I_BCC: branch(!p[F_C], ea[7:0], base_cyc);
            I_BCS: branch(p[F_C], ea[7:0], base_cyc);
            I_BEQ: branch(p[F_Z], ea[7:0], base_cyc);
            I_BNE: branch(!p[F_Z], ea[7:0], base_cyc);
            I_BMI: branch(p[F_N], ea[7:0], base_cyc);
            I_BPL: branch(!p[F_N], ea[7:0], base_cyc);
            I_BVS: branch(p[F_V], ea[7:0], base_cyc);
            I_BVC: branch(!p[F_V], ea[7:0], base_cyc);
            I_BIT: begin
                m = rd(ea);
                p[F_Z] = ((a & m) == 8'h00);
                p[F_V] = m[6];
                p[F_N] = m[7];
            end
            I_BRK: begin
                pc = pc + 16'd1;
                enter_vector(VEC_IRQ, 1'b1);
            end
            I_CLC: p[F_C] = 1'b0;
            I_CLD: p[F_D] = 1'b0;
            I_CLI: p[F_I] = 1'b0;
            I_CLV: p[F_V] = 1'b0;
            I_SEC: p[F_C] = 1'b1;
            I_SED: p[F_D] = 1'b1;
            I_SEI: p[F_I] = 1'b1;
            I_CMP: compare(a, rd(ea));
            I_CPX: compare(x, rd(ea));
            I_CPY: compare(y, rd(ea));
            I_DEC: begin r = rd(ea) - 8'd1; set_zn(r); mem[ea] = r; end
            I_INC: begin r = rd(ea) + 8'd1; set_zn(r); mem[ea] = r; end
            I_DEX: begin x = x - 8'd1; set_zn(x); end
            I_DEY: begin y = y - 8'd1; set_zn(y); end
            I_INX: begin x = x + 8'd1; set_zn(x); end
            I_INY: begin y = y + 8'd1; set_zn(y); end
            I_JMP: pc = ea;
            I_JSR: begin
                ret = pc - 16'd1;
                push(ret[15:8]);
                push(ret[7:0]);
                pc = ea;
            end
            I_LDA: begin a = rd(ea); set_zn(a); end
            I_LDX: begin x = rd(ea); set_zn(x); end
            I_LDY: begin y = rd(ea); set_zn(y); end
            I_PHA: push(a);
            I_PHP: begin p[F_U] = 1'b1; push(p | 8'h10); end
            I_PLA: begin pull(a); set_zn(a); end
            I_PLP: begin pull(m); p = m; p[F_B] = 1'b0; p[F_U] = 1'b1; end
            I_RTI: begin
                pull(m);
                p = m;
                p[F_B] = 1'b0;
                p[F_U] = 1'b1;
                pull(lo);
                pull(m);
                pc = {m, lo};
            end
            I_RTS: begin
                pull(lo);
                pull(m);
                pc = {m, lo} + 16'd1;
            end
            I_STA: mem[ea] = a;
            I_STX: mem[ea] = x;
            I_STY: mem[ea] = y;
            I_TAX: begin x = a; set_zn(x); end
            I_TAY: begin y = a; set_zn(y); end
            I_TSX: begin x = sp; set_zn(x); end
            I_TXA: begin a = x; set_zn(a); end
            I_TXS: sp = x;
            I_TYA: begin a = y; set_zn(a); end
            default: ;
        endcase
        cyc += base_cyc;
    endtask

    task automatic load_registers();
        a  = 8'h00;
        x  = 8'h00;
        y  = 8'h00;
        sp = SP_RESET;
        p  = P_RESET;
        pc = rd16(VEC_RST);
    endtask

    task automatic predict_request(input t_req rq, output t_rsp e);
        int         cyc;
        logic [7:0] rdata;
        cyc = 0;
        rdata = 8'h00;
        if (rq.nmi_set) nmi_latched = 1'b1;
        case (t_op'(rq.op))
            OP_RUN: begin
                if (nmi_latched) begin
                    nmi_latched = 1'b0;
                    enter_vector(VEC_NMI, 1'b0);
                    cyc = 7;
                end else if (rq.irq_line && !p[F_I]) begin
                    enter_vector(VEC_IRQ, 1'b0);
                    cyc = 7;
                end
                run_instruction(cyc);
            end
            OP_WR: mem[rq.addr] = rq.wdata;
            OP_RD: rdata = mem[rq.addr];
            default: load_registers();
        endcase
        e.pc_out    = pc;
        e.acc_out   = a;
        e.x_out     = x;
        e.y_out     = y;
        e.sp_out    = sp;
        e.flags_out = p;
        e.cycles    = cyc[4:0];
        e.rdata     = rdata;
    endtask

    always @(posedge i_clk) begin
        t_rsp e;
        if (!i_rst_n) begin
            // The program counter stays zero until the first reset request.
            a  = 8'h00;
            x  = 8'h00;
            y  = 8'h00;
            sp = SP_RESET;
            p  = P_RESET;
            pc = 16'h0000;
            nmi_latched = 1'b0;
            results_due.delete();
            fails = 0;
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (results_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result %h", $time, i_rsp);
                end else begin
                    e = results_due.pop_front();
                    if (i_rsp !== e) begin
                        fails++;
                        $display("%0t: mismatch expected pc=%h a=%h x=%h y=%h sp=%h p=%h cyc=%0d rd=%h",
                                 $time, e.pc_out, e.acc_out, e.x_out, e.y_out, e.sp_out,
                                 e.flags_out, e.cycles, e.rdata);
                        $display("%0t:          actual   pc=%h a=%h x=%h y=%h sp=%h p=%h cyc=%0d rd=%h",
                                 $time, i_rsp.pc_out, i_rsp.acc_out, i_rsp.x_out, i_rsp.y_out,
                                 i_rsp.sp_out, i_rsp.flags_out, i_rsp.cycles, i_rsp.rdata);
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                predict_request(i_req, e);
                results_due.push_back(e);
            end
        end
    end

endmodule

/* dv/cpu_6502_instruction_step_tb.sv */
// Top of the 6502 step core testbench: clock, reset, request stimulus and verdict.
// Depends on cpu65_pkg, cpu_6502_instruction_step and cpu_6502_instruction_step_chk.
`timescale 1ns / 1ps

module cpu_6502_instruction_step_tb;
    import cpu65_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    t_req req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    t_rsp rsp;
    int   fail_count;
    int   pending;
    bit   gaps_on = 1'b0;
    int   stall_left = 0;

    always #1 i_clk = ~i_clk;

    cpu_6502_instruction_step i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (rsp)
    );

    cpu_6502_instruction_step_chk i_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_valid),
        .i_req_stall  (req_stall),
        .i_req        (req),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_stall  (rsp_stall),
        .i_rsp        (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if (!gaps_on) begin
            rsp_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            rsp_stall  <= ($urandom_range(0, 2) == 0);
            stall_left <= $urandom_range(1, 10);
        end
    end

    task automatic send(input t_op op, input logic [15:0] addr, input logic [7:0] data,
                        input logic nmi, input logic irq);
        t_req r;
        r.op       = op;
        r.addr     = addr;
        r.wdata    = data;
        r.nmi_set  = nmi;
        r.irq_line = irq;
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge i_clk); while (req_stall);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic put(input logic [15:0] addr, input logic [7:0] data);
        send(OP_WR, addr, data, 1'b0, 1'b0);
    endtask

    initial begin
        int kind;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every byte gets a defined value first, so that any fetch is legal.
        for (int addr = 0; addr < 65536; addr++) begin
            put(addr[15:0], 8'($urandom));
        end

        gaps_on = 1'b1;
        put(VEC_RST, 8'h00);
        put(VEC_RST + 16'd1, 8'h02);
        send(OP_RST, 16'h0000, 8'h00, 1'b0, 1'b0);
        put(16'h0200, 8'hA9);
        put(16'h0201, 8'h80);
        put(16'h0202, 8'h69);
        put(16'h0203, 8'h80);
        put(16'h0204, 8'h58);
        put(16'h0205, 8'h6C);
        put(16'h0206, 8'hFF);
        put(16'h0207, 8'h02);
        // Load of 0x80, then an add that overflows to zero with carry out.
        send(OP_RUN, 16'h0000, 8'h00, 1'b0, 1'b0);
        send(OP_RUN, 16'h0000, 8'h00, 1'b0, 1'b0);
        // Clear I, then an indirect jump whose pointer sits at the end of a page.
        send(OP_RUN, 16'h0000, 8'h00, 1'b0, 1'b1);
        send(OP_RUN, 16'h0000, 8'h00, 1'b0, 1'b0);
        send(OP_RUN, 16'h0000, 8'h00, 1'b0, 1'b1);
        // The NMI request on a write is latched and taken by the next step.
        send(OP_WR, 16'hFFFF, 8'hFF, 1'b1, 1'b0);
        send(OP_RUN, 16'hFFFF, 8'hFF, 1'b0, 1'b1);
        send(OP_RD, 16'hFFFF, 8'h00, 1'b0, 1'b0);
        send(OP_RD, 16'h0000, 8'h00, 1'b0, 1'b0);

        for (int n = 0; n < 450; n++) begin
            if (n == 200) begin
                req_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            if (n == 390) gaps_on = 1'b0;
            kind = $urandom_range(0, 99);
            if (kind < 72) begin
                send(OP_RUN, 16'($urandom), 8'($urandom), $urandom_range(0, 19) == 0,
                     $urandom_range(0, 2) == 0);
            end else if (kind < 87) begin
                send(OP_WR, 16'($urandom), 8'($urandom), $urandom_range(0, 19) == 0,
                     1'($urandom));
            end else if (kind < 97) begin
                send(OP_RD, 16'($urandom), 8'($urandom), $urandom_range(0, 19) == 0,
                     1'($urandom));
            end else begin
                send(OP_RST, 16'($urandom), 8'($urandom), $urandom_range(0, 9) == 0,
                     1'($urandom));
            end
        end
        req_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
